FILE: sv/kpm_pkg.sv
package kpm_pkg;

  localparam int unsigned ROM_SIZE               = 22;
  localparam int unsigned PAT_TEXT_LEN           = 9;
  localparam int unsigned NUM_PATTERNS_DEFAULT   = 22;
  localparam int unsigned MAX_POSITION_DEFAULT   = 64;
  localparam int unsigned FIRST_GROUP_SIZE_DEFAULT = 6;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] COUNT_MAX  = 8'hFF;

  localparam logic [1:0] FM_OFF   = 2'd0;
  localparam logic [1:0] FM_FIRST = 2'd1;
  localparam logic [1:0] FM_ALL   = 2'd2;

  typedef struct packed {
    logic [PAT_TEXT_LEN*8-1:0] text;
    logic [3:0]                len;
    logic                      prefix;
    logic                      valid;
  } pat_entry_t;

  typedef struct packed {
    logic       cmp_en;
    logic       last;
    logic [1:0] mode;
  } kpm_ctrl_t;

  localparam pat_entry_t PAT_ROM [ROM_SIZE] = '{
    '{text: 72'("FAG"),       len: 4'd3, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("HOMO"),      len: 4'd4, prefix: 1'b0, valid: 1'b1},
    '{text: 72'("SLUT"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("NIGG"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("PUSSY"),     len: 4'd5, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("TRANN"),     len: 4'd5, prefix: 1'b1, valid: 1'b1},
    '{text: 72'h0,            len: 4'd0, prefix: 1'b0, valid: 1'b0},
    '{text: 72'("CUM"),       len: 4'd3, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("SEX"),       len: 4'd3, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("FUCK"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("SHIT"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("DICK"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("PORN"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("COCK"),      len: 4'd4, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("BITCH"),     len: 4'd5, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("DILDO"),     len: 4'd5, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("PENIS"),     len: 4'd5, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("VAGINA"),    len: 4'd6, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("ORGASM"),    len: 4'd6, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("BULLSH"),    len: 4'd6, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("MOTHERFUC"), len: 4'd9, prefix: 1'b1, valid: 1'b1},
    '{text: 72'("MASTURBAT"), len: 4'd9, prefix: 1'b1, valid: 1'b1}
  };

endpackage

FILE: sv/kpm_match.sv
module kpm_match
  import kpm_pkg::*;
#(
  parameter int unsigned NUM_PATTERNS     = NUM_PATTERNS_DEFAULT,
  parameter int unsigned FIRST_GROUP_SIZE = FIRST_GROUP_SIZE_DEFAULT,
  parameter int unsigned POS_W            = 7
) (
  input  logic [7:0]              char_i,
  input  logic [POS_W-1:0]        pos_i,
  input  logic [NUM_PATTERNS-1:0] alive_i,
  input  kpm_ctrl_t               ctrl_i,
  output logic [NUM_PATTERNS-1:0] alive_o,
  output logic                    hit_o
);

  logic [NUM_PATTERNS-1:0] hit;

  for (genvar j = 0; j < NUM_PATTERNS; j++) begin : g_pat
    if (j < ROM_SIZE) begin : g_rom
      localparam pat_entry_t  ENTRY    = PAT_ROM[j];
      localparam int unsigned LEN      = int'(ENTRY.len);
      localparam bit          IN_FIRST = (j < FIRST_GROUP_SIZE);

      if (ENTRY.valid) begin : g_live
        logic en;
        logic char_ok;
        logic at_end;

        always_comb begin
          unique case (ctrl_i.mode)
            FM_OFF:   en = 1'b0;
            FM_FIRST: en = IN_FIRST;
            default:  en = 1'b1;
          endcase
        end

        always_comb begin
          char_ok = 1'b0;
          for (int k = 0; k < LEN; k++) begin
            char_ok |= (pos_i == POS_W'(k)) &&
                       (char_i == ENTRY.text[8*(LEN-1-k) +: 8]);
          end
          at_end = (pos_i == POS_W'(LEN - 1));
        end

        always_comb begin
          alive_o[j] = alive_i[j];
          hit[j]     = 1'b0;
          if (ctrl_i.cmp_en && en && alive_i[j]) begin
            if (!char_ok) begin
              alive_o[j] = 1'b0;
            end else if (at_end) begin
              if (ENTRY.prefix || ctrl_i.last) begin
                hit[j] = 1'b1;
              end else begin
                alive_o[j] = 1'b0;
              end
            end
          end
        end
      end else begin : g_sep
        assign alive_o[j] = alive_i[j];
        assign hit[j]     = 1'b0;
      end
    end else begin : g_none
      assign alive_o[j] = alive_i[j];
      assign hit[j]     = 1'b0;
    end
  end

  assign hit_o = |hit;

endmodule

FILE: sv/keyword_prefix_matcher.sv
// Keyword prefix matcher: one character item per cycle on the input channel
// (in_valid_i / in_stall_o) carrying char_code_i with token_start_i,
// word_start_i and last_of_word_i. Every pattern of the constant pattern
// table is compared in parallel against the current character position.
// Only the final character of a word yields an item on the output channel
// (out_valid_o / out_stall_i): matched_o and tokens_to_skip_o (token count
// of the word, saturating at 255, zero when unmatched).
// filter_mode (0 disables all patterns, 1 enables the first group, 2 or 3
// all) is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block is idle, which the block does not enforce. A result
// passes the input register, the single compare pass, then the result
// register; while in_stall_o is low, this pass takes one item per cycle.
// A stalled output holds its item; the input keeps accepting items that
// give no result, and stalls once a final character meets a full result
// register. Reset clears the word state, empties both registers and sets
// filter_mode to 0.
module keyword_prefix_matcher
  import kpm_pkg::*;
#(
  parameter int unsigned NUM_PATTERNS     = NUM_PATTERNS_DEFAULT,
  parameter int unsigned MAX_POSITION     = MAX_POSITION_DEFAULT,
  parameter int unsigned FIRST_GROUP_SIZE = FIRST_GROUP_SIZE_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       token_start_i,
  input  logic       word_start_i,
  input  logic       last_of_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic [7:0] tokens_to_skip_o
);

  localparam int unsigned POS_W = $clog2(MAX_POSITION + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_POSITION);

  logic [1:0] mode_q;

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       tok_q;
  logic       wst_q;
  logic       last_q;

  logic [NUM_PATTERNS-1:0] alive_q, alive_d, alive_eff;
  logic [POS_W-1:0]        pos_q, pos_d, pos_eff;
  logic                    wmatch_q, wmatch_d, wmatch_eff;
  logic [7:0]              count_q, count_d, count_eff;

  logic       out_valid_q;
  logic       matched_q;
  logic [7:0] skip_q;

  logic       advance;
  logic       load;
  logic       tok_eff;
  logic       skip_char;
  logic       pos_open;
  logic       hit;
  kpm_ctrl_t  ctrl;

  assign advance    = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  assign alive_eff  = wst_q ? {NUM_PATTERNS{1'b1}} : alive_q;
  assign pos_eff    = wst_q ? '0 : pos_q;
  assign wmatch_eff = wst_q ? 1'b0 : wmatch_q;
  assign count_eff  = wst_q ? '0 : count_q;
  assign tok_eff    = tok_q || wst_q;
  assign skip_char  = tok_eff && (char_q == SPACE_CHAR);
  assign pos_open   = (pos_eff < POS_MAX);

  assign ctrl.cmp_en = !wmatch_eff && pos_open && !skip_char;
  assign ctrl.last   = last_q;
  assign ctrl.mode   = mode_q;

  kpm_match #(
    .NUM_PATTERNS     (NUM_PATTERNS),
    .FIRST_GROUP_SIZE (FIRST_GROUP_SIZE),
    .POS_W            (POS_W)
  ) u_match (
    .char_i  (char_q),
    .pos_i   (pos_eff),
    .alive_i (alive_eff),
    .ctrl_i  (ctrl),
    .alive_o (alive_d),
    .hit_o   (hit)
  );

  assign wmatch_d = wmatch_eff || hit;
  assign pos_d    = (!skip_char && pos_open) ? pos_eff + POS_W'(1) : pos_eff;
  assign count_d  = (tok_eff && count_eff != COUNT_MAX) ? count_eff + 8'd1 : count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FM_OFF;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_code_i;
      tok_q  <= token_start_i;
      wst_q  <= word_start_i;
      last_q <= last_of_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q  <= {NUM_PATTERNS{1'b1}};
      pos_q    <= '0;
      wmatch_q <= 1'b0;
      count_q  <= '0;
    end else if (advance) begin
      alive_q  <= alive_d;
      pos_q    <= pos_d;
      wmatch_q <= wmatch_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      matched_q <= wmatch_d;
      skip_q    <= wmatch_d ? count_d : 8'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign matched_o        = matched_q;
  assign tokens_to_skip_o = skip_q;

endmodule

FILE: test/tb_keyword_prefix_matcher.sv
`timescale 1ns / 1ps

module tb_keyword_prefix_matcher
  import kpm_pkg::*;
();

  localparam int unsigned LATENCY     = 2;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 24;
  localparam logic [1:0]  FM_ALL_ALT  = 2'd3;

  typedef struct packed {
    logic       has;
    logic       m;
    logic [7:0] t;
  } verdict_t;

  typedef struct packed {
    logic [1:0] mode;
    int         pat;
    logic [7:0] lit;
    int         extra;
    bit         lead;
    bit         split;
    bit         ws;
    bit         typed;
    bit         exp_m;
    logic [7:0] exp_t;
  } word_row_t;

  // mode, pattern (-1: literal), literal, extra, lead, split, ws, typed, matched, tokens
  localparam word_row_t DIRECTED [9] = '{
    '{FM_OFF,     -1, 8'h00, 0, 0, 0, 0, 1, 0, 8'd0},
    '{FM_OFF,      0, 8'h00, 0, 0, 0, 1, 1, 0, 8'd0},
    '{FM_FIRST,    0, 8'h00, 0, 0, 0, 1, 0, 0, 8'd0},
    '{FM_FIRST,    1, 8'h00, 1, 0, 0, 1, 0, 0, 8'd0},
    '{FM_FIRST,    1, 8'h00, 0, 1, 0, 1, 0, 0, 8'd0},
    '{FM_FIRST,    9, 8'h00, 0, 0, 0, 1, 0, 0, 8'd0},
    '{FM_ALL,      9, 8'h00, 2, 0, 1, 1, 0, 0, 8'd0},
    '{FM_ALL,     -1, 8'hFF, 0, 0, 0, 1, 1, 0, 8'd0},
    '{FM_ALL_ALT,  7, 8'h00, 0, 1, 1, 1, 0, 0, 8'd0}
  };

  localparam logic [1:0] PHASE_MODE [PHASES] = '{
    FM_ALL, FM_FIRST, FM_ALL, FM_ALL_ALT, FM_OFF, FM_ALL, FM_FIRST, FM_ALL
  };
  localparam int SEND_IDLE  [4] = '{0, 64, 0, 31};
  localparam int RECV_STALL [4] = '{0, 0, 64, 31};

  logic       clk_i;
  logic       rst_ni           = 1'b0;
  logic       cfg_we_i         = 1'b0;
  logic [1:0] cfg_wdata_i      = 2'd0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i      = 8'd0;
  logic       token_start_i    = 1'b0;
  logic       word_start_i     = 1'b0;
  logic       last_of_word_i   = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic       matched_o;
  logic [7:0] tokens_to_skip_o;

  keyword_prefix_matcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .token_start_i    (token_start_i),
    .word_start_i     (word_start_i),
    .last_of_word_i   (last_of_word_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .matched_o        (matched_o),
    .tokens_to_skip_o (tokens_to_skip_o)
  );

  logic [NUM_PATTERNS_DEFAULT-1:0] alive_q     = '1;
  int unsigned                     char_pos_q  = 0;
  logic                            word_hit_q  = 1'b0;
  logic [7:0]                      token_cnt_q = 8'd0;
  logic [1:0]                      filter_mode_q = FM_OFF;

  verdict_t   pending_verdicts [$];
  logic [7:0] word_chars [$];
  bit         word_toks [$];

  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          break_pct   = 0;
  int          hold_reqs   = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] pat_char(int j, int k);
    return PAT_ROM[j].text[(int'(PAT_ROM[j].len) - 1 - k) * 8 +: 8];
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(65, 90));
  endfunction

  function automatic verdict_t match_step(logic [7:0] ch, logic tok, logic ws, logic last);
    verdict_t v;
    logic     tok_en;
    logic     hit;
    logic     en;
    int       j;
    tok_en = tok | ws;
    if (ws) begin
      alive_q     = '1;
      char_pos_q  = 0;
      word_hit_q  = 1'b0;
      token_cnt_q = 8'd0;
    end
    if (tok_en && token_cnt_q < COUNT_MAX) token_cnt_q++;
    if (!(tok_en && ch == SPACE_CHAR)) begin
      if (!word_hit_q && char_pos_q < MAX_POSITION_DEFAULT) begin
        hit = 1'b0;
        for (j = 0; j < NUM_PATTERNS_DEFAULT; j++) begin
          en = j < ROM_SIZE && PAT_ROM[j].valid && filter_mode_q != FM_OFF &&
               (filter_mode_q != FM_FIRST || j < FIRST_GROUP_SIZE_DEFAULT);
          if (!hit && en && alive_q[j]) begin
            if (char_pos_q >= PAT_ROM[j].len || pat_char(j, char_pos_q) != ch) begin
              alive_q[j] = 1'b0;
            end else if (char_pos_q + 1 == PAT_ROM[j].len) begin
              if (PAT_ROM[j].prefix || last) hit = 1'b1;
              else alive_q[j] = 1'b0;
            end
          end
        end
        if (hit) word_hit_q = 1'b1;
      end
      if (char_pos_q < MAX_POSITION_DEFAULT) char_pos_q++;
    end
    v.has = last;
    v.m   = word_hit_q;
    v.t   = word_hit_q ? token_cnt_q : 8'd0;
    return v;
  endfunction

  task automatic send_char(logic [7:0] ch, logic tok, logic ws, logic last,
                           bit typed, bit em, logic [7:0] et);
    verdict_t v;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_code_i    <= ch;
    token_start_i  <= tok;
    word_start_i   <= ws;
    last_of_word_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    v = match_step(ch, tok, ws, last);
    if (v.has) begin
      if (typed) begin
        v.m = em;
        v.t = et;
      end
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic emit_word(bit ws, bit close, bit typed, bit em, logic [7:0] et);
    int  i;
    bit  brk;
    for (i = 0; i < word_chars.size(); i++) begin
      brk = $urandom_range(0, 99) < break_pct;
      send_char(word_chars[i], word_toks[i], (i == 0) ? ws : brk,
                close && i == word_chars.size() - 1, typed, em, et);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    // let items that give no result leave the pipeline
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    filter_mode_q = m;
  endtask

  task automatic random_word();
    int         kind;
    int         j;
    int         n;
    int         k;
    logic [7:0] c;
    word_chars.delete();
    word_toks.delete();
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      word_chars.push_back(SPACE_CHAR);
      word_toks.push_back(1'b1);
    end
    if (kind < 60) begin
      j = $urandom_range(0, ROM_SIZE - 1);
      n = PAT_ROM[j].len;
      if (n > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n - 1);
      for (k = 0; k < n; k++) begin
        c = pat_char(j, k);
        if ($urandom_range(0, 9) == 0) c = rand_letter();
        if ($urandom_range(0, 9) == 0) begin
          word_chars.push_back(SPACE_CHAR);
          word_toks.push_back(1'b1);
        end
        word_chars.push_back(c);
        word_toks.push_back($urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          word_chars.push_back(rand_letter());
          word_toks.push_back($urandom_range(0, 7) == 0);
        end
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) begin
        word_chars.push_back(rand_letter());
        word_toks.push_back($urandom_range(0, 7) == 0);
      end
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 6)) begin
        word_chars.push_back(8'($urandom_range(0, 255)));
        word_toks.push_back($urandom_range(0, 1));
      end
    end else begin
      // run past the saturating character position
      j = $urandom_range(0, ROM_SIZE - 1);
      if ($urandom_range(0, 1) == 0) begin
        for (k = 0; k < PAT_ROM[j].len; k++) begin
          word_chars.push_back(pat_char(j, k));
          word_toks.push_back(1'b0);
        end
      end
      n = $urandom_range(64, 70);
      while (word_chars.size() < n) begin
        word_chars.push_back(rand_letter());
        word_toks.push_back($urandom_range(0, 15) == 0);
      end
    end
    if (word_chars.size() == 0) begin
      word_chars.push_back(rand_letter());
      word_toks.push_back(1'b1);
    end
    emit_word($urandom_range(0, 9) != 0, $urandom_range(0, 19) != 0, 1'b0, 1'b0, 8'd0);
  endtask

  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result matched=%0b tokens_to_skip=%0d",
                 $time, matched_o, tokens_to_skip_o);
        mismatches++;
      end else begin
        v = pending_verdicts.pop_front();
        if (matched_o !== v.m) begin
          $display("%0t: matched expected %0b actual %0b", $time, v.m, matched_o);
          mismatches++;
        end
        if (tokens_to_skip_o !== v.t) begin
          $display("%0t: tokens_to_skip expected %0d actual %0d",
                   $time, v.t, tokens_to_skip_o);
          mismatches++;
        end
      end
    end
    if (holds_done != hold_reqs) begin
      hold_left  = HOLD_CYCLES;
      holds_done = hold_reqs;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** keyword_prefix_matcher: FAILED **");
      $finish;
    end
  end

  initial begin
    int        i;
    int        k;
    int        p;
    int        j;
    int        target;
    int        half;
    bit        paused;
    word_row_t row;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.mode != filter_mode_q) set_mode(row.mode);
      word_chars.delete();
      word_toks.delete();
      if (row.lead) begin
        word_chars.push_back(SPACE_CHAR);
        word_toks.push_back(1'b1);
      end
      if (row.pat < 0) begin
        word_chars.push_back(row.lit);
        word_toks.push_back(1'b1);
      end else begin
        for (k = 0; k < PAT_ROM[row.pat].len; k++) begin
          word_chars.push_back(pat_char(row.pat, k));
          word_toks.push_back(k == 0 || (row.split && k == 1));
        end
      end
      repeat (row.extra) begin
        word_chars.push_back(8'h58);
        word_toks.push_back(1'b0);
      end
      emit_word(row.ws, 1'b1, row.typed, row.exp_m, row.exp_t);
    end

    for (p = 0; p < PHASES; p++) begin
      set_mode(PHASE_MODE[p]);
      idle_pct  = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      break_pct = 2;
      if (p == 1) begin
        // hold the output while one-character words pile up
        hold_reqs <= hold_reqs + 1;
        repeat (10) begin
          word_chars.delete();
          word_toks.delete();
          word_chars.push_back(rand_letter());
          word_toks.push_back(1'b1);
          emit_word(1'b1, 1'b1, 1'b0, 1'b0, 8'd0);
        end
      end
      if (p == 2) begin
        // saturate the token count on a matched word
        word_chars.delete();
        word_toks.delete();
        j = $urandom_range(7, ROM_SIZE - 1);
        for (k = 0; k < PAT_ROM[j].len; k++) begin
          word_chars.push_back(pat_char(j, k));
          word_toks.push_back(k == 0);
        end
        repeat (290) begin
          word_chars.push_back(rand_letter());
          word_toks.push_back(1'b1);
        end
        break_pct = 0;
        emit_word(1'b1, 1'b1, 1'b0, 1'b0, 8'd0);
        break_pct = 2;
      end
      target = items_sent + PHASE_ITEMS;
      half   = items_sent + PHASE_ITEMS / 2;
      paused = 1'b0;
      while (items_sent < target) begin
        if (p == 5 && !paused && items_sent >= half) begin
          drain();
          paused = 1'b1;
        end
        random_word();
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("** keyword_prefix_matcher: PASSED **");
    end else begin
      $display("** keyword_prefix_matcher: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/kpm_pkg.sv
sv/kpm_match.sv
sv/keyword_prefix_matcher.sv
test/tb_keyword_prefix_matcher.sv
